@@ src/assert_macros.svh @@
// Assertion macros used by the checker file of this block.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TWKC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("two-wire master check failed");

// Next-cycle implication, disabled while reset is asserted.
`define TWKC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("two-wire master check failed");

`endif

@@ src/twkc_pkg.sv @@
// Shared types and constants of the two-wire key chip master.
// No dependencies.
package twkc_pkg;

  localparam int BYTE_BITS = 8;
  localparam int BIT_W     = $clog2(BYTE_BITS);
  localparam logic [BIT_W-1:0] BIT_LAST = BIT_W'(BYTE_BITS - 1);

  localparam int STEP_W  = 16;
  localparam int CFG_AW  = 3;
  localparam int CFG_DW  = 32;

  // Register index of the step length register
  localparam logic [0:0] REG_CYCLES_PER_STEP = 1'b0;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2,
    OP_RSVD  = 2'd3
  } twkc_op_t;

  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_SETUP     = 4'd1,
    PH_START     = 4'd2,
    PH_START_LOW = 4'd3,
    PH_CMD       = 4'd4,
    PH_ACK       = 4'd5,
    PH_RBIT      = 4'd6,
    PH_WBIT      = 4'd7,
    PH_REND      = 4'd8,
    PH_STOP      = 4'd9
  } twkc_phase_t;

  typedef struct packed {
    logic [1:0]           opcode;
    logic [BYTE_BITS-1:0] command_byte;
    logic [BYTE_BITS-1:0] write_byte;
    logic                 sda_in;
  } twkc_in_t;

  typedef struct packed {
    logic                 scl_level;
    logic                 sda_level;
    logic                 sda_drive;
    logic                 busy_res;
    logic                 done_res;
    logic [BYTE_BITS-1:0] read_byte;
  } twkc_out_t;

endpackage

@@ src/twkc_seq.sv @@
// Pin waveform sequencer: phase state, step timer, shift registers.
// Depends on twkc_pkg. One beat advances the waveform by one tick.
module twkc_seq import twkc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              beat_en,
  input  twkc_in_t          beat,
  input  logic [STEP_W-1:0] step_len,
  output twkc_out_t         res
);

  twkc_phase_t          phase_r, phase_nxt;
  logic [1:0]           sub_r, sub_nxt;
  logic [BIT_W-1:0]     bit_r, bit_nxt;
  logic [BYTE_BITS-1:0] cmd_r, cmd_nxt;
  logic [BYTE_BITS-1:0] dat_r, dat_nxt;
  logic                 rd_r, rd_nxt;
  logic [STEP_W-1:0]    tick_r, tick_nxt;
  logic [BYTE_BITS-1:0] last_rd_r, last_rd_nxt;

  // Effective state after a possible start on this beat
  logic                 start;
  twkc_phase_t          ph;
  logic [1:0]           sub;
  logic [BIT_W-1:0]     bidx;
  logic [BYTE_BITS-1:0] cmd;
  logic [BYTE_BITS-1:0] dat;
  logic                 rd;
  logic [STEP_W-1:0]    tick;
  logic                 busy;
  logic                 step_end;
  logic                 done;
  logic [STEP_W:0]      len;
  logic                 scl, sda, drv;

  // Start decode: a start opcode is taken only while idle
  always_comb begin
    start = (phase_r == PH_IDLE) &&
            ((beat.opcode == OP_WRITE) || (beat.opcode == OP_READ));
    ph    = start ? PH_SETUP : phase_r;
    sub   = start ? 2'd0 : sub_r;
    bidx  = start ? BIT_LAST : bit_r;
    cmd   = start ? beat.command_byte : cmd_r;
    rd    = start ? (beat.opcode == OP_READ) : rd_r;
    dat   = start ? ((beat.opcode == OP_READ) ? '0 : beat.write_byte) : dat_r;
    tick  = start ? '0 : tick_r;
    busy  = (ph != PH_IDLE);
    // zero step length behaves as one
    len   = (step_len == '0) ? (STEP_W+1)'(1) : {1'b0, step_len};
    step_end = busy && (({1'b0, tick} + (STEP_W+1)'(1)) >= len);
  end

  // Line levels for the current step
  always_comb begin
    scl = 1'b1;
    sda = 1'b1;
    drv = 1'b0;
    case (ph)
      PH_SETUP:     begin scl = 1'b1; sda = 1'b1; drv = 1'b1; end
      PH_START:     begin scl = 1'b1; sda = 1'b0; drv = 1'b1; end
      PH_START_LOW: begin scl = 1'b0; sda = 1'b0; drv = 1'b1; end
      PH_CMD:       begin scl = (sub == 2'd1); sda = cmd[bidx]; drv = 1'b1; end
      PH_WBIT:      begin scl = (sub == 2'd1); sda = dat[bidx]; drv = 1'b1; end
      PH_ACK:       begin scl = (sub == 2'd1); sda = 1'b1; drv = 1'b0; end
      PH_RBIT:      begin scl = (sub == 2'd0); sda = 1'b1; drv = 1'b0; end
      PH_REND:      begin scl = 1'b1; sda = 1'b1; drv = 1'b1; end
      PH_STOP: begin
        scl = (sub != 2'd0);
        sda = (sub == 2'd2);
        drv = 1'b1;
      end
      default:      begin scl = 1'b1; sda = 1'b1; drv = 1'b0; end
    endcase
  end

  // Next state at the end of each timing step
  always_comb begin
    phase_nxt   = ph;
    sub_nxt     = sub;
    bit_nxt     = bidx;
    cmd_nxt     = cmd;
    dat_nxt     = dat;
    rd_nxt      = rd;
    last_rd_nxt = last_rd_r;
    done        = 1'b0;
    tick_nxt    = busy ? (step_end ? '0 : tick + STEP_W'(1)) : tick;
    if (step_end) begin
      case (ph)
        PH_SETUP:     phase_nxt = PH_START;
        PH_START:     phase_nxt = PH_START_LOW;
        PH_START_LOW: begin
          phase_nxt = PH_CMD;
          sub_nxt   = 2'd0;
          bit_nxt   = BIT_LAST;
        end
        PH_CMD, PH_WBIT: begin
          if (sub != 2'd2) begin
            sub_nxt = sub + 2'd1;
          end else begin
            sub_nxt = 2'd0;
            if (bidx == '0) begin
              phase_nxt = (ph == PH_CMD) ? PH_ACK : PH_STOP;
            end else begin
              bit_nxt = bidx - BIT_W'(1);
            end
          end
        end
        PH_ACK: begin
          if (sub != 2'd2) begin
            sub_nxt = sub + 2'd1;
          end else begin
            sub_nxt   = 2'd0;
            bit_nxt   = BIT_LAST;
            phase_nxt = rd ? PH_RBIT : PH_WBIT;
          end
        end
        PH_RBIT: begin
          if (sub == 2'd0) begin
            // sample on the last tick of the clock-high step
            dat_nxt[bidx] = dat[bidx] | beat.sda_in;
            sub_nxt       = 2'd1;
          end else begin
            sub_nxt = 2'd0;
            if (bidx == '0) phase_nxt = PH_REND;
            else            bit_nxt   = bidx - BIT_W'(1);
          end
        end
        PH_REND: done = 1'b1;
        PH_STOP: begin
          if (sub != 2'd2) sub_nxt = sub + 2'd1;
          else             done    = 1'b1;
        end
        default: phase_nxt = PH_IDLE;
      endcase
      if (done) begin
        if (rd) last_rd_nxt = dat_nxt;
        phase_nxt = PH_IDLE;
        sub_nxt   = 2'd0;
        bit_nxt   = BIT_LAST;
      end
    end
  end

  // Result of this beat; idle shows both lines high, data released
  always_comb begin
    res.scl_level = busy ? scl : 1'b1;
    res.sda_level = busy ? sda : 1'b1;
    res.sda_drive = busy ? drv : 1'b0;
    res.busy_res  = busy;
    res.done_res  = done;
    res.read_byte = last_rd_nxt;
  end

  // State registers, advanced once per accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      sub_r     <= 2'd0;
      bit_r     <= BIT_LAST;
      cmd_r     <= '0;
      dat_r     <= '0;
      rd_r      <= 1'b0;
      tick_r    <= '0;
      last_rd_r <= '0;
    end else if (beat_en) begin
      phase_r   <= phase_nxt;
      sub_r     <= sub_nxt;
      bit_r     <= bit_nxt;
      cmd_r     <= cmd_nxt;
      dat_r     <= dat_nxt;
      rd_r      <= rd_nxt;
      tick_r    <= tick_nxt;
      last_rd_r <= last_rd_nxt;
    end
  end

endmodule

@@ src/two_wire_key_chip_master.sv @@
// Two-wire key chip master: one result beat per input beat (one pin tick).
// The result is registered, in the output register or, behind a held one, the skid entry.
// Throughput: one beat per cycle while the skid entry is free; a two-entry output
// buffer (register + skid) keeps input flowing while one result waits. Sync active-low
// reset: idle, step length 1, last read byte 0. Depends on twkc_pkg and twkc_seq.
module two_wire_key_chip_master import twkc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  // input beats
  input  logic              in_valid,
  output logic              in_stall,
  input  twkc_in_t          in_data,
  // result beats
  output logic              out_valid,
  input  logic              out_stall,
  output twkc_out_t         out_data,
  // register port
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  logic [STEP_W-1:0] step_len_r;
  logic              cfg_wr;
  logic              in_acc;
  logic              out_pop;
  twkc_out_t         res;
  twkc_out_t         out_r, skid_r;
  logic              out_vld_r, skid_vld_r;

  // Register port: single register at byte address 0
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[CFG_AW-1] == REG_CYCLES_PER_STEP) ?
                      {(CFG_DW-STEP_W)'(0), step_len_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_len_r <= STEP_W'(1);
    end else if (cfg_wr && (cfg_paddr[CFG_AW-1] == REG_CYCLES_PER_STEP)) begin
      step_len_r <= cfg_pwdata[STEP_W-1:0];
    end
  end

  // Handshake: stall only when the skid entry is occupied
  assign in_stall = skid_vld_r;
  assign in_acc   = in_valid && !skid_vld_r;
  assign out_pop  = out_vld_r && !out_stall;

  twkc_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .beat_en  (in_acc),
    .beat     (in_data),
    .step_len (step_len_r),
    .res      (res)
  );

  // Output register plus skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (out_pop) begin
      if (skid_vld_r) begin
        skid_vld_r <= 1'b0;
      end else begin
        out_vld_r <= in_acc;
      end
    end else if (in_acc) begin
      if (out_vld_r) skid_vld_r <= 1'b1;
      else           out_vld_r  <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_pop) begin
      out_r <= skid_vld_r ? skid_r : res;
    end else if (in_acc) begin
      if (out_vld_r) skid_r <= res;
      else           out_r  <= res;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule

@@ src/twkc_chk.sv @@
// Port checker for the two-wire key chip master, bound to the top level.
// Depends on twkc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module twkc_chk import twkc_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_stall,
  input twkc_out_t out_data
);

  // a stalled result beat stays and holds its payload
  `TWKC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
                    out_valid && $stable(out_data))

  // done only on a busy beat
  `TWKC_ASSERT_NOW(a_done_busy, clk, rst_n, out_valid && out_data.done_res,
                   out_data.busy_res)

  // idle lines: clock high, data high and released
  `TWKC_ASSERT_NOW(a_idle_lines, clk, rst_n, out_valid && !out_data.busy_res,
                   out_data.scl_level && out_data.sda_level && !out_data.sda_drive)

  // released data reads high
  `TWKC_ASSERT_NOW(a_release_high, clk, rst_n, out_valid && !out_data.sda_drive,
                   out_data.sda_level)

endmodule

bind two_wire_key_chip_master twkc_chk u_twkc_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

@@ tb/tb_two_wire_key_chip_master.sv @@
// Testbench for the two-wire key chip master: drives pin ticks, predicts the
// pin waveform and read byte of every beat, and checks each result beat.
// Depends on twkc_pkg and the two_wire_key_chip_master RTL.
`timescale 1ns / 100ps

module tb_two_wire_key_chip_master;
  import twkc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam logic [CFG_AW-1:0] STEP_LEN_ADDR = CFG_AW'(4 * int'(REG_CYCLES_PER_STEP));
  // pin triple as {drive, sda, scl}
  localparam logic [2:0] LINES_IDLE = 3'b011;

  // one row of the directed stimulus; reps > 1 repeats the beat
  typedef struct packed {
    twkc_op_t  op;
    logic [7:0] cmd;
    logic [7:0] wb;
    logic       sda;
    logic       sda_rnd;
    logic [7:0] reps;
    logic       typed;
    twkc_out_t  want;
  } stim_row_t;

  localparam int NUM_ROWS = 19;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_valid = 1'b0;
  logic            in_stall;
  twkc_in_t        in_data = '0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  twkc_out_t       out_data;
  logic            cfg_psel = 1'b0;
  logic            cfg_penable = 1'b0;
  logic            cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr = '0;
  logic [CFG_DW-1:0] cfg_pwdata = '0;
  logic [CFG_DW-1:0] cfg_prdata;
  logic            cfg_pready;

  // predicted block state
  twkc_phase_t seq_phase = PH_IDLE;
  logic [1:0]  seq_sub = 2'd0;
  logic [2:0]  seq_bit = BIT_LAST;
  logic [7:0]  cmd_sr = 8'h00;
  logic [7:0]  data_sr = 8'h00;
  logic        rd_xfer = 1'b0;
  logic [15:0] step_ticks = 16'd0;
  logic [2:0]  held_lines = LINES_IDLE;
  logic [7:0]  last_rd = 8'h00;
  logic [15:0] step_len = 16'd1;

  twkc_out_t   pin_expect_q[$];
  int          fail_cnt = 0;
  int unsigned cycle_cnt = 0;
  int          stall_pct = 0;
  int          stall_left = 0;

  // step lengths walked by the random part: zero, max and small values
  logic [15:0] step_lens [9] = '{16'd0, 16'd2, 16'd3, 16'hFFFF, 16'd1, 16'd5, 16'd1,
                                 16'd2, 16'd1};

  // directed rows, all at the reset step length of one tick
  stim_row_t dir_tbl [NUM_ROWS] = '{
    // idle tick and reserved opcode while idle: held idle levels
    '{OP_TICK,  8'h00, 8'h00, 1'b1, 1'b0, 8'd1,  1'b1, '{1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00}},
    '{OP_RSVD,  8'hFF, 8'hFF, 1'b0, 1'b0, 8'd1,  1'b1, '{1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00}},
    // write starts on the same tick: both lines high, then start condition
    '{OP_WRITE, 8'hA5, 8'h3C, 1'b0, 1'b0, 8'd1,  1'b1, '{1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 8'h00}},
    '{OP_READ,  8'h5A, 8'hC3, 1'b0, 1'b0, 8'd1,  1'b1, '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 8'h00}},
    '{OP_TICK,  8'h00, 8'h00, 1'b0, 1'b1, 8'd20, 1'b0, '0},
    '{OP_RSVD,  8'h00, 8'h00, 1'b0, 1'b1, 8'd5,  1'b0, '0},
    '{OP_WRITE, 8'hFF, 8'hFF, 1'b1, 1'b0, 8'd5,  1'b0, '0},
    '{OP_TICK,  8'h00, 8'h00, 1'b0, 1'b1, 8'd25, 1'b0, '0},
    // read of all ones
    '{OP_READ,  8'hFF, 8'h00, 1'b1, 1'b0, 8'd1,  1'b1, '{1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 8'h00}},
    '{OP_TICK,  8'h00, 8'h00, 1'b1, 1'b0, 8'd46, 1'b0, '0},
    '{OP_TICK,  8'h00, 8'h00, 1'b0, 1'b0, 8'd1,  1'b1, '{1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 8'hFF}},
    // read of all zeros
    '{OP_READ,  8'h00, 8'hFF, 1'b0, 1'b0, 8'd1,  1'b1, '{1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 8'hFF}},
    '{OP_TICK,  8'h00, 8'h00, 1'b0, 1'b0, 8'd46, 1'b0, '0},
    '{OP_TICK,  8'h00, 8'h00, 1'b1, 1'b0, 8'd1,  1'b1, '{1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00}},
    // write with command zero and data all ones, then a mixed read
    '{OP_WRITE, 8'h00, 8'hFF, 1'b0, 1'b1, 8'd1,  1'b0, '0},
    '{OP_TICK,  8'h00, 8'h00, 1'b0, 1'b1, 8'd56, 1'b0, '0},
    '{OP_READ,  8'h81, 8'h00, 1'b0, 1'b1, 8'd1,  1'b0, '0},
    '{OP_TICK,  8'h00, 8'h00, 1'b0, 1'b1, 8'd46, 1'b0, '0},
    '{OP_TICK,  8'h00, 8'h00, 1'b0, 1'b1, 8'd3,  1'b0, '0}
  };

  two_wire_key_chip_master u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  task automatic cmp_field(input string name, input logic [7:0] exp_v, input logic [7:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      fail_cnt++;
    end
  endtask

  // Drive one tick beat, wait for it to be taken, then advance the pin
  // waveform prediction and queue the expected result beat.
  task automatic send_tick(input twkc_in_t beat, input bit typed, input twkc_out_t want);
    logic [2:0]  lv;
    logic [16:0] len;
    logic        busy;
    logic        done;
    twkc_out_t   pred;
    in_valid <= 1'b1;
    in_data  <= beat;
    @(posedge clk);
    while (in_stall) @(posedge clk);

    busy = 1'b0;
    done = 1'b0;
    len = (step_len == 16'd0) ? 17'd1 : {1'b0, step_len};
    // a start opcode is taken only while idle
    if (seq_phase == PH_IDLE && (beat.opcode == OP_WRITE || beat.opcode == OP_READ)) begin
      seq_phase  = PH_SETUP;
      seq_sub    = 2'd0;
      seq_bit    = BIT_LAST;
      step_ticks = 16'd0;
      cmd_sr     = beat.command_byte;
      rd_xfer    = (beat.opcode == OP_READ);
      data_sr    = rd_xfer ? 8'h00 : beat.write_byte;
    end
    if (seq_phase == PH_IDLE) begin
      lv = held_lines;
    end else begin
      busy = 1'b1;
      // levels of the current step
      case (seq_phase)
        PH_SETUP, PH_REND: lv = 3'b111;
        PH_START:          lv = 3'b101;
        PH_START_LOW:      lv = 3'b100;
        PH_CMD:            lv = {1'b1, cmd_sr[seq_bit], seq_sub == 2'd1};
        PH_WBIT:           lv = {1'b1, data_sr[seq_bit], seq_sub == 2'd1};
        PH_ACK:            lv = {2'b01, seq_sub == 2'd1};
        PH_RBIT:           lv = {2'b01, seq_sub == 2'd0};
        PH_STOP:           lv = (seq_sub == 2'd0) ? 3'b100 :
                                (seq_sub == 2'd1) ? 3'b101 : 3'b111;
        default:           lv = held_lines;
      endcase
      held_lines = lv;
      if ({1'b0, step_ticks} + 17'd1 >= len) begin
        // end of a timing step
        step_ticks = 16'd0;
        case (seq_phase)
          PH_SETUP: seq_phase = PH_START;
          PH_START: seq_phase = PH_START_LOW;
          PH_START_LOW: begin
            seq_phase = PH_CMD;
            seq_sub   = 2'd0;
            seq_bit   = BIT_LAST;
          end
          PH_CMD, PH_WBIT: begin
            if (seq_sub != 2'd2) begin
              seq_sub = seq_sub + 2'd1;
            end else begin
              seq_sub = 2'd0;
              if (seq_bit == 3'd0) seq_phase = (seq_phase == PH_CMD) ? PH_ACK : PH_STOP;
              else seq_bit = seq_bit - 3'd1;
            end
          end
          PH_ACK: begin
            if (seq_sub != 2'd2) begin
              seq_sub = seq_sub + 2'd1;
            end else begin
              seq_sub   = 2'd0;
              seq_bit   = BIT_LAST;
              seq_phase = rd_xfer ? PH_RBIT : PH_WBIT;
            end
          end
          PH_RBIT: begin
            // sample on the last tick of the clock-high step
            if (seq_sub == 2'd0) begin
              data_sr[seq_bit] = data_sr[seq_bit] | beat.sda_in;
              seq_sub = 2'd1;
            end else begin
              seq_sub = 2'd0;
              if (seq_bit == 3'd0) seq_phase = PH_REND;
              else seq_bit = seq_bit - 3'd1;
            end
          end
          PH_REND: done = 1'b1;
          PH_STOP: begin
            if (seq_sub != 2'd2) seq_sub = seq_sub + 2'd1;
            else done = 1'b1;
          end
          default: seq_phase = PH_IDLE;
        endcase
        if (done) begin
          if (rd_xfer) last_rd = data_sr;
          seq_phase  = PH_IDLE;
          seq_sub    = 2'd0;
          seq_bit    = BIT_LAST;
          held_lines = LINES_IDLE;
        end
      end else begin
        step_ticks = step_ticks + 16'd1;
      end
    end
    pred.scl_level = lv[0];
    pred.sda_level = lv[1];
    pred.sda_drive = lv[2];
    pred.busy_res  = busy;
    pred.done_res  = done;
    pred.read_byte = last_rd;
    pin_expect_q.push_back(typed ? want : pred);
  endtask

  // Result side: check each taken beat, stall on a pattern of varying density
  always @(posedge clk) begin : result_check
    twkc_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pin_expect_q.size() == 0) begin
        $error("result beat with nothing expected");
        fail_cnt++;
      end else begin
        want = pin_expect_q.pop_front();
        cmp_field("scl_level", want.scl_level, out_data.scl_level);
        cmp_field("sda_level", want.sda_level, out_data.sda_level);
        cmp_field("sda_drive", want.sda_drive, out_data.sda_drive);
        cmp_field("busy_res",  want.busy_res,  out_data.busy_res);
        cmp_field("done_res",  want.done_res,  out_data.done_res);
        cmp_field("read_byte", want.read_byte, out_data.read_byte);
      end
    end
    if (stall_left == 0) begin
      case ($urandom_range(0, 3))
        0:       stall_pct = 0;
        1:       stall_pct = 25;
        2:       stall_pct = 50;
        default: stall_pct = 80;
      endcase
      stall_left = $urandom_range(16, 128);
    end else begin
      stall_left--;
    end
    out_stall <= rst_n && ($urandom_range(0, 99) < stall_pct);
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    twkc_in_t    beat;
    int          burst;
    int          n_items;
    logic [15:0] len_sel;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows at the reset step length
    for (int r = 0; r < NUM_ROWS; r++) begin
      for (int k = 0; k < int'(dir_tbl[r].reps); k++) begin
        beat.opcode       = dir_tbl[r].op;
        beat.command_byte = dir_tbl[r].cmd;
        beat.write_byte   = dir_tbl[r].wb;
        beat.sda_in       = dir_tbl[r].sda_rnd ? 1'($urandom) : dir_tbl[r].sda;
        send_tick(beat, dir_tbl[r].typed && dir_tbl[r].reps == 8'd1, dir_tbl[r].want);
      end
    end

    // random traffic, one step length per phase
    for (int p = 0; p < 9; p++) begin
      len_sel = step_lens[p];
      n_items = (len_sel == 16'hFFFF) ? 40 : 131;

      // drain, then write the step length and read it back
      in_valid <= 1'b0;
      while (pin_expect_q.size() != 0) @(posedge clk);
      cfg_psel    <= 1'b1;
      cfg_penable <= 1'b0;
      cfg_pwrite  <= 1'b1;
      cfg_paddr   <= STEP_LEN_ADDR;
      cfg_pwdata  <= {16'($urandom), len_sel};
      @(posedge clk);
      cfg_penable <= 1'b1;
      @(posedge clk);
      while (!cfg_pready) @(posedge clk);
      step_len = len_sel;
      cfg_penable <= 1'b0;
      cfg_pwrite  <= 1'b0;
      @(posedge clk);
      cfg_penable <= 1'b1;
      @(posedge clk);
      while (!cfg_pready) @(posedge clk);
      if (cfg_prdata[STEP_W-1:0] !== len_sel) begin
        $error("cycles_per_step: expected %0h, got %0h", len_sel, cfg_prdata[STEP_W-1:0]);
        fail_cnt++;
      end
      cfg_psel    <= 1'b0;
      cfg_penable <= 1'b0;

      // bursts of beats with random gaps; mostly whole transactions
      burst = 0;
      for (int i = 0; i < n_items; i++) begin
        if (burst == 0) begin
          burst = $urandom_range(1, 48);
          if ($urandom_range(0, 2) != 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
          end
        end
        beat.command_byte = 8'($urandom);
        beat.write_byte   = 8'($urandom);
        beat.sda_in       = 1'($urandom);
        if (seq_phase == PH_IDLE) begin
          case ($urandom_range(0, 9))
            0, 1, 2: beat.opcode = OP_WRITE;
            3, 4, 5: beat.opcode = OP_READ;
            6:       beat.opcode = OP_RSVD;
            default: beat.opcode = OP_TICK;
          endcase
        end else begin
          // stray opcodes mid-transaction are ignored by the block
          beat.opcode = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(0, 3)) : OP_TICK;
        end
        send_tick(beat, 1'b0, '0);
        burst--;
      end
    end

    in_valid <= 1'b0;
    while (pin_expect_q.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (fail_cnt == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+src
src/twkc_pkg.sv
src/twkc_seq.sv
src/two_wire_key_chip_master.sv
src/twkc_chk.sv
tb/tb_two_wire_key_chip_master.sv
